/* sv/lsp_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the LIFO stack.
package lsp_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int POS_W  = 7;
    localparam int CAP_W  = 7;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 7;
    localparam int CMP_W  = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
                                            : ((POS_W > CAP_W) ? POS_W : CAP_W);

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TOP  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [DATA_W-1:0] FAIL_WORD = '1;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_rd;
    } lsp_cmd_t;

    typedef struct packed {
        logic needs_read;
    } lsp_sts_t;

endpackage

/* sv/lifo_stack_with_peek.sv */
// Top level of the LIFO stack with peek: controller plus datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | mode, push_value, position
//  out     | out_valid/out_stall | read_data, status, entry_count, is_empty, is_full
//  cfg     | cfg_we              | cfg_wdata (capacity in use)
//
// Push and rejected items: the result is registered when the item executes; pop, peek
// and top reads first pass through the read state for the entry store's registered port.
// One item is held at a time; the next is taken once the held one's result has been
// loaded into the result register, and execution waits while a stalled result is held.
// Reset empties the stack and sets capacity to 64; the store itself is not cleared.
// A stalled result holds in the result register while the next item is accepted.
module lifo_stack_with_peek (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lsp_pkg::MODE_W-1:0]        mode,
    input  logic signed [lsp_pkg::DATA_W-1:0] push_value,
    input  logic [lsp_pkg::POS_W-1:0]         position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lsp_pkg::DATA_W-1:0] read_data,
    output logic [lsp_pkg::STAT_W-1:0]        status,
    output logic [lsp_pkg::OCNT_W-1:0]        entry_count,
    output logic                              is_empty,
    output logic                              is_full,
    input  logic                              cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0]         cfg_wdata
);
    import lsp_pkg::*;

    lsp_cmd_t cmd;
    lsp_sts_t sts;

    lsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    lsp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mode       (mode),
        .push_value (push_value),
        .position   (position),
        .read_data  (read_data),
        .status     (status),
        .entry_count(entry_count),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule

/* sv/lsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/lsp_ctrl.sv */
// Controller: item hand-off, execute and read sequencing, result register valid.
module lsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lsp_pkg::lsp_cmd_t cmd,
    input  lsp_pkg::lsp_sts_t sts
);
    import lsp_pkg::*;

    localparam logic [1:0] S_EMPTY = 2'd0;
    localparam logic [1:0] S_ITEM  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       load_out;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        cmd        = '0;
        load_out   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_EMPTY:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ITEM;
                end
            end
            S_ITEM:
            begin
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.needs_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        load_out   = 1'b1;
                        state_next = S_EMPTY;
                    end
                end
            end
            S_READ:
            begin
                cmd.load_rd = 1'b1;
                load_out    = 1'b1;
                state_next  = S_EMPTY;
            end
            default:
            begin
                state_next = S_EMPTY;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_EMPTY);
    assign out_valid = out_valid_reg;

    // result register must already be free while the read is in flight
    a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !out_valid_reg)
        else $error("result register busy during read");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_ITEM)
        else $error("accepted item not held");

    a_exec_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> state_reg == S_ITEM && out_free)
        else $error("execute without free result register");

endmodule

/* sv/lsp_dp.sv */
// Datapath: held item, count and capacity, bounds checks, entry store, result register.
module lsp_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsp_pkg::lsp_cmd_t            cmd,
    output lsp_pkg::lsp_sts_t            sts,
    input  logic                         cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic [lsp_pkg::MODE_W-1:0]   mode,
    input  logic signed [lsp_pkg::DATA_W-1:0] push_value,
    input  logic [lsp_pkg::POS_W-1:0]    position,
    output logic signed [lsp_pkg::DATA_W-1:0] read_data,
    output logic [lsp_pkg::STAT_W-1:0]   status,
    output logic [lsp_pkg::OCNT_W-1:0]   entry_count,
    output logic                         is_empty,
    output logic                         is_full
);
    import lsp_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] word_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] data_reg;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]  rcount_reg;
    logic              empty_reg;
    logic              full_reg;

    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  cap_w;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  rd_idx;
    logic [STAT_W-1:0] status_next;
    logic              ram_we;
    logic              rd_ok;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] ram_rdata;

    always_comb
    begin
        cnt_w = CMP_W'(count_reg);
        pos_w = CMP_W'(pos_reg);
        cap_w = CMP_W'(cap_reg);
        if (cap_w == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_w > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_w;
        end

        status_next = ST_OK;
        count_next  = count_reg;
        ram_we      = 1'b0;
        rd_ok       = 1'b0;
        rd_idx      = cnt_w - CMP_W'(1);
        case (mode_reg)
            MODE_PUSH:
            begin
                if (cnt_w >= eff_cap)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_PEEK:
            begin
                rd_idx = cnt_w - pos_w;
                if (pos_w == '0 || pos_w > cnt_w)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
        endcase
        raddr          = rd_idx[ADDR_W-1:0];
        sts.needs_read = rd_ok;
    end

    lsp_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (cmd.exec && ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(word_reg),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            word_reg <= push_value;
            pos_reg  <= position;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rcount_reg <= count_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= (CMP_W'(count_next) >= eff_cap);
            if (!rd_ok)
            begin
                data_reg <= FAIL_WORD;
            end
        end
        if (cmd.load_rd)
        begin
            data_reg <= ram_rdata;
        end
    end

    assign read_data   = data_reg;
    assign status      = status_reg;
    assign entry_count = OCNT_W'(rcount_reg);
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("count beyond depth");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && ram_we |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance count");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && status_next != ST_OK |=> $stable(count_reg))
        else $error("rejected item changed count");

endmodule

/* tb/stack_checker.sv */
// Result checker for the LIFO stack: predicts each item's result and compares it on the output.
module stack_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [lsp_pkg::MODE_W-1:0]        mode,
    input  logic signed [lsp_pkg::DATA_W-1:0] push_value,
    input  logic [lsp_pkg::POS_W-1:0]         position,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [lsp_pkg::DATA_W-1:0] read_data,
    input  logic [lsp_pkg::STAT_W-1:0]        status,
    input  logic [lsp_pkg::OCNT_W-1:0]        entry_count,
    input  logic                              is_empty,
    input  logic                              is_full,
    input  logic                              cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0]         cfg_wdata,
    output int                                fail_count,
    output int                                pending,
    output logic [lsp_pkg::OCNT_W-1:0]        depth_now
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsp_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] st;
        logic [OCNT_W-1:0] cnt;
        logic              empty;
        logic              full;
    } stack_result_t;

    logic [DATA_W-1:0] stack_words [DEPTH];
    logic [OCNT_W-1:0] held;
    logic [CAP_W-1:0]  cap_reg;
    stack_result_t     expected_q [$];
    stack_result_t     want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        depth_now  = '0;
    end

    // register value clamped to 1..DEPTH
    function automatic logic [OCNT_W-1:0] usable_capacity(logic [CAP_W-1:0] r);
        if (r == '0)
            return OCNT_W'(1);
        if (r > DEPTH)
            return OCNT_W'(DEPTH);
        return OCNT_W'(r);
    endfunction

    // applies one item to the shadow stack and returns its result
    function automatic stack_result_t apply_stack_op(logic [MODE_W-1:0] m,
                                                     logic [DATA_W-1:0] w,
                                                     logic [POS_W-1:0]  p);
        stack_result_t     r;
        logic [OCNT_W-1:0] lim;
        lim    = usable_capacity(cap_reg);
        r.data = FAIL_WORD;
        r.st   = ST_OK;
        case (m)
            MODE_PUSH:
            begin
                if (held >= lim || held >= DEPTH)
                    r.st = ST_OVERFLOW;
                else
                begin
                    stack_words[ADDR_W'(held)] = w;
                    held = held + 1'b1;
                end
            end
            MODE_POP:
            begin
                if (held == '0)
                    r.st = ST_UNDERFLOW;
                else
                begin
                    held   = held - 1'b1;
                    r.data = stack_words[ADDR_W'(held)];
                end
            end
            MODE_PEEK:
            begin
                if (p < 1 || p > held)
                    r.st = ST_BADPOS;
                else
                    r.data = stack_words[ADDR_W'(held - p)];
            end
            default:
            begin
                if (held == '0)
                    r.st = ST_UNDERFLOW;
                else
                    r.data = stack_words[ADDR_W'(held - 1'b1)];
            end
        endcase
        r.cnt   = held;
        r.empty = (held == '0);
        r.full  = (held >= lim);
        return r;
    endfunction

    task automatic check_field(string field, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
        if (exp !== act)
        begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, field, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held    = '0;
            cap_reg = CAP_RESET;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: unexpected item, data 0x%0h status %0d count %0d",
                             $time, read_data, status, entry_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("read_data", want.data, read_data);
                    check_field("status", DATA_W'(want.st), DATA_W'(status));
                    check_field("entry_count", DATA_W'(want.cnt), DATA_W'(entry_count));
                    check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
                    check_field("is_full", DATA_W'(want.full), DATA_W'(is_full));
                end
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (in_valid && !in_stall)
                expected_q.push_back(apply_stack_op(mode, push_value, position));
        end
        pending   = expected_q.size();
        depth_now = held;
    end

endmodule

/* tb/tb.sv */
// Top of the LIFO stack testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsp_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_LEN  = 150;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] push_value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] read_data;
    logic [STAT_W-1:0]        status;
    logic [OCNT_W-1:0]        entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     cfg_we;
    logic [CAP_W-1:0]         cfg_wdata;

    int                       mismatches;
    int                       results_pending;
    logic [OCNT_W-1:0]        stack_depth;
    int                       long_hold_req;

    int cap_plan [13] = '{64, 1, 3, 0, 64, 127, 8, 64, 100, 2, 40, 64, 64};
    int push_pcts [4] = '{85, 15, 50, 30};

    lifo_stack_with_peek dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .push_value  (push_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    stack_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .push_value  (push_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (mismatches),
        .pending     (results_pending),
        .depth_now   (stack_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short, sometimes medium, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic offer(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                         input logic [POS_W-1:0] p, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= m;
        push_value <= v;
        position   <= p;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // stop offering and wait for every outstanding item's result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input int v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item(input int push_pct);
        logic [MODE_W-1:0] m;
        logic [DATA_W-1:0] v;
        logic [POS_W-1:0]  p;
        int                r;
        int                held;
        held = int'(stack_depth);
        v    = $urandom;
        r    = $urandom_range(0, 19);
        if (r == 0)
            v = 32'h7FFF_FFFF;
        else if (r == 1)
            v = 32'h8000_0000;
        else if (r == 2)
            v = '0;
        else if (r == 3)
            v = '1;
        if ($urandom_range(0, 9) == 0)
        begin
            m = MODE_W'($urandom_range(0, 3));
            p = POS_W'($urandom_range(0, 127));
        end
        else
        begin
            if ($urandom_range(0, 99) < push_pct)
                m = MODE_PUSH;
            else
            begin
                r = $urandom_range(0, 2);
                m = (r == 0) ? MODE_POP : ((r == 1) ? MODE_PEEK : MODE_TOP);
            end
            r = $urandom_range(0, 9);
            if (r < 7)
                p = POS_W'($urandom_range(1, (held > 0) ? held : 1));
            else if (r == 7)
                p = '0;
            else if (r == 8)
                p = POS_W'(held + 1);
            else
                p = POS_W'($urandom_range(0, DEPTH));
        end
        offer(m, v, p, ($urandom_range(0, 99) < 60) ? 0 : pick_gap());
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        int run;
        int stall;
        int holds_done;
        holds_done = 0;
        out_stall  = 1'b0;
        forever
        begin
            if (long_hold_req != holds_done)
            begin
                holds_done++;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            stall = pick_gap();
            repeat (stall)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int pct;
        long_hold_req = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_PUSH;
        push_value    = '0;
        position      = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // empty stack, extremes of data and position
        offer(MODE_POP, '0, '0, 0);
        offer(MODE_TOP, '1, 7'd1, 0);
        offer(MODE_PEEK, '0, 7'd1, 0);
        offer(MODE_PUSH, 32'h7FFF_FFFF, '0, 0);
        offer(MODE_PUSH, 32'h8000_0000, 7'd127, 1);
        offer(MODE_PUSH, '0, '0, 0);
        offer(MODE_PUSH, '1, '0, 0);
        offer(MODE_PEEK, '0, '0, 2);
        offer(MODE_PEEK, '0, 7'd1, 0);
        offer(MODE_PEEK, '0, 7'd4, 0);
        offer(MODE_PEEK, '0, 7'd5, 0);
        offer(MODE_PEEK, '0, 7'd127, 0);
        offer(MODE_TOP, '0, '0, 0);
        offer(MODE_POP, '0, '0, 0);
        offer(MODE_POP, '0, '0, 0);

        // capacity reached, then lowered below the count
        drain();
        write_capacity(2);
        offer(MODE_PUSH, 32'h1234_5678, '0, 0);
        offer(MODE_POP, '0, '0, 0);
        offer(MODE_PUSH, 32'hA5A5_5A5A, '0, 0);
        offer(MODE_PUSH, 32'h0F0F_F0F0, '0, 0);
        drain();
        write_capacity(0);
        offer(MODE_PUSH, 32'h5555_5555, '0, 0);
        offer(MODE_PEEK, '0, 7'd2, 0);
        offer(MODE_POP, '0, '0, 0);
        offer(MODE_POP, '0, '0, 0);
        offer(MODE_POP, '0, '0, 0);

        foreach (cap_plan[ph])
        begin
            drain();
            write_capacity(cap_plan[ph]);
            pct = push_pcts[0];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n > 0 && $urandom_range(0, 39) == 0)
                    pct = push_pcts[$urandom_range(0, 3)];
                if (n == 10 && (ph == 0 || ph == 7))
                    long_hold_req++;
                random_item(pct);
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
